// ===== hw/rtl/opk_pkg.sv =====
// ----------------------------------------------------------------------------
// opk_pkg: shared types and constants of the order preserving key encoder
// Request, result and internal job formats, key type codes, widths.
// ----------------------------------------------------------------------------
package opk_pkg;

  localparam int KEY_TYPE_W = 4;
  localparam int WORD_W     = 128;
  localparam int BYTE_W     = 8;
  localparam int NBYTES_W   = 5;   // holds 0..16 bytes per job
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef logic [KEY_TYPE_W-1:0] key_type_t;
  typedef logic [NBYTES_W-1:0]   nbytes_t;

  localparam key_type_t KT_UINT8   = 4'd0;
  localparam key_type_t KT_UINT16  = 4'd1;
  localparam key_type_t KT_UINT32  = 4'd2;
  localparam key_type_t KT_UINT64  = 4'd3;
  localparam key_type_t KT_INT8    = 4'd4;
  localparam key_type_t KT_INT16   = 4'd5;
  localparam key_type_t KT_INT32   = 4'd6;
  localparam key_type_t KT_INT64   = 4'd7;
  localparam key_type_t KT_UINT128 = 4'd8;
  localparam key_type_t KT_INT128  = 4'd9;
  localparam key_type_t KT_FLOAT   = 4'd10;
  localparam key_type_t KT_DOUBLE  = 4'd11;
  localparam key_type_t KT_STRING  = 4'd12;
  localparam key_type_t KT_BOOL    = 4'd13;

  localparam key_type_t KEY_TYPE_RESET = KT_UINT64;

  typedef struct packed {
    logic [63:0] value_low;
    logic [63:0] value_high;
    logic [7:0]  char_byte;
    logic        char_valid;
    logic        string_end;
    logic        key_null;
  } request_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       key_last;
    logic       key_empty;
  } result_t;

  // One classified key: bytes packed from the top of word, most significant first.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    nbytes_t           nbytes;
    logic              last_en;
    logic              empty;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ===== hw/rtl/order_preserving_key_encoder.sv =====
// ----------------------------------------------------------------------------
// order_preserving_key_encoder: typed key to order-preserving byte string
// Top level: key type register, classifier, job queue and byte serializer.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter through push/full; a request is taken on a clock edge with
//   push high and full low. Results leave as a queue: while empty is low the
//   oldest byte sits on result, and pop high takes it.
//   cfg_we/cfg_data write the key type; write it only while the block is idle.
//   Each request becomes a run of result bytes: 1 to 16 for fixed types
//   (key_last on the final one), 0 to 3 for string items (key_last only on the
//   terminator), one byte with key_empty for a null key. Unknown types and
//   empty non-final string items give nothing.
// Timing:
//   A request's first byte reaches result through a queue write and then a
//   serializer load, and can be popped at the next edge.
//   The serializer sends one byte per cycle while the receiver pops, and
//   loads the next job in the cycle its last byte is taken.
//   The job queue (QUEUE_DEPTH entries) lets requests keep arriving while the
//   receiver stalls; full rises when it fills and no byte is lost.
// Reset: rst (synchronous) empties the queue and serializer and sets the key
//   type to uint64.
// ----------------------------------------------------------------------------
module order_preserving_key_encoder #(
  parameter int QUEUE_DEPTH = opk_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  opk_pkg::request_t  request,
  output logic               empty,
  input  logic               pop,
  output opk_pkg::result_t   result,
  input  logic               cfg_we,
  input  opk_pkg::key_type_t cfg_data
);

  opk_pkg::key_type_t key_type;
  opk_pkg::qstat_t    qstat;
  opk_pkg::job_t      front_job;
  opk_pkg::job_t      queue_job;
  logic               q_push;
  logic               q_pop;

  // Hold the key type until the next configuration write.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_type <= opk_pkg::KEY_TYPE_RESET;
    end else if (cfg_we) begin
      key_type <= cfg_data;
    end
  end

  // Accept whenever the job queue has room; nothing else holds back a request.
  assign full = qstat.full;

  // Classify the request into encoded bytes and flags.
  opk_front u_front (
    .key_type (key_type),
    .push     (push),
    .request  (request),
    .qstat    (qstat),
    .q_push   (q_push),
    .job      (front_job)
  );

  // Decouple classification from serialization.
  opk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (front_job),
    .pop     (q_pop),
    .rd_data (queue_job),
    .qstat   (qstat)
  );

  // Shift bytes out, advancing only when the receiver pops.
  opk_back u_back (
    .clk    (clk),
    .rst    (rst),
    .job    (queue_job),
    .qstat  (qstat),
    .q_pop  (q_pop),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

endmodule

// ===== hw/rtl/opk_front.sv =====
// ----------------------------------------------------------------------------
// opk_front: request classifier
// Turns one request into a job: the encoded bytes, their count and flags.
// ----------------------------------------------------------------------------
module opk_front (
  input  opk_pkg::key_type_t key_type,
  input  logic               push,
  input  opk_pkg::request_t  request,
  input  opk_pkg::qstat_t    qstat,
  output logic               q_push,
  output opk_pkg::job_t      job
);

  logic flip;
  logic pre;
  logic [63:0] lo;
  logic [63:0] hi;

  assign lo = request.value_low;
  assign hi = request.value_high;

  always_comb begin
    job         = '0;
    job.last_en = 1'b1;
    flip        = (key_type >= opk_pkg::KT_INT8);
    pre         = request.char_valid && (request.char_byte <= 8'd1);
    if (request.key_null) begin
      job.nbytes = opk_pkg::nbytes_t'(1);
      job.empty  = 1'b1;
    end else begin
      case (key_type)
        opk_pkg::KT_UINT8, opk_pkg::KT_INT8: begin
          job.word[127:120] = lo[7:0] ^ {flip, 7'b0};
          job.nbytes        = opk_pkg::nbytes_t'(1);
        end
        opk_pkg::KT_UINT16, opk_pkg::KT_INT16: begin
          job.word[127:112] = lo[15:0] ^ {flip, 15'b0};
          job.nbytes        = opk_pkg::nbytes_t'(2);
        end
        opk_pkg::KT_UINT32, opk_pkg::KT_INT32: begin
          job.word[127:96] = lo[31:0] ^ {flip, 31'b0};
          job.nbytes       = opk_pkg::nbytes_t'(4);
        end
        opk_pkg::KT_UINT64, opk_pkg::KT_INT64: begin
          job.word[127:64] = lo ^ {flip, 63'b0};
          job.nbytes       = opk_pkg::nbytes_t'(8);
        end
        opk_pkg::KT_UINT128, opk_pkg::KT_INT128: begin
          job.word   = {hi ^ {(key_type == opk_pkg::KT_INT128), 63'b0}, lo};
          job.nbytes = opk_pkg::nbytes_t'(16);
        end
        opk_pkg::KT_FLOAT: begin
          job.word[127:96] = lo[31] ? ~lo[31:0] : {1'b1, lo[30:0]};
          job.nbytes       = opk_pkg::nbytes_t'(4);
        end
        opk_pkg::KT_DOUBLE: begin
          job.word[127:64] = lo[63] ? ~lo : {1'b1, lo[62:0]};
          job.nbytes       = opk_pkg::nbytes_t'(8);
        end
        opk_pkg::KT_STRING: begin
          // escape byte, character, terminator; the terminator is zero already
          if (pre) begin
            job.word[127:104] = {8'd1, request.char_byte, 8'd0};
          end else if (request.char_valid) begin
            job.word[127:104] = {request.char_byte, 16'd0};
          end
          job.nbytes  = opk_pkg::nbytes_t'(pre) + opk_pkg::nbytes_t'(request.char_valid)
                      + opk_pkg::nbytes_t'(request.string_end);
          job.last_en = request.string_end;
        end
        opk_pkg::KT_BOOL: begin
          job.word[127:120] = {7'b0, |lo};
          job.nbytes        = opk_pkg::nbytes_t'(1);
        end
        default: begin
          job.nbytes = '0;
        end
      endcase
    end
  end

  // drop requests that encode to nothing
  assign q_push = push && !qstat.full && (job.nbytes != '0);

endmodule

// ===== hw/rtl/opk_queue.sv =====
// ----------------------------------------------------------------------------
// opk_queue: job queue
// Short first-in first-out store between the classifier and the serializer.
// ----------------------------------------------------------------------------
module opk_queue #(
  parameter int DEPTH = opk_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  opk_pkg::job_t   wr_data,
  input  logic            pop,
  output opk_pkg::job_t   rd_data,
  output opk_pkg::qstat_t qstat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  opk_pkg::job_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign qstat.full  = (count == CNT_W'(DEPTH));
  assign qstat.empty = (count == '0);
  assign rd_data     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && qstat.full && !pop))
    else $error("job queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && qstat.empty))
    else $error("job queue read while empty");
`endif

endmodule

// ===== hw/rtl/opk_back.sv =====
// ----------------------------------------------------------------------------
// opk_back: byte serializer
// Loads one job at a time and shifts its bytes out, one per accepted result.
// ----------------------------------------------------------------------------
module opk_back (
  input  logic            clk,
  input  logic            rst,
  input  opk_pkg::job_t   job,
  input  opk_pkg::qstat_t qstat,
  output logic            q_pop,
  input  logic            pop,
  output logic            empty,
  output opk_pkg::result_t result
);

  logic                           busy;
  logic [opk_pkg::WORD_W-1:0]     word;
  opk_pkg::nbytes_t               remain;
  logic                           last_en;
  logic                           key_empty;
  logic                           take;
  logic                           final_byte;

  assign empty      = !busy;
  assign take       = pop && busy;
  assign final_byte = (remain == opk_pkg::nbytes_t'(1));
  assign q_pop      = !qstat.empty && (!busy || (take && final_byte));

  assign result.out_byte  = word[opk_pkg::WORD_W-1 -: opk_pkg::BYTE_W];
  assign result.key_last  = final_byte && last_en;
  assign result.key_empty = key_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (q_pop) begin
      busy <= 1'b1;
    end else if (take && final_byte) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      word      <= job.word;
      remain    <= job.nbytes;
      last_en   <= job.last_en;
      key_empty <= job.empty;
    end else if (take) begin
      word   <= {word[opk_pkg::WORD_W-opk_pkg::BYTE_W-1:0], {opk_pkg::BYTE_W{1'b0}}};
      remain <= remain - opk_pkg::nbytes_t'(1);
    end
  end

`ifndef SYNTHESIS
  a_busy_has_bytes: assert property (@(posedge clk) disable iff (rst)
    busy |-> (remain != '0))
    else $error("serializer busy with no bytes left");
  a_empty_key_last: assert property (@(posedge clk) disable iff (rst)
    (busy && key_empty) |-> result.key_last)
    else $error("empty-key result without key_last");
`endif

endmodule

// ===== bench/key_encoding_checker.sv =====
// ----------------------------------------------------------------------------
// key_encoding_checker: result predictor and comparator for the key encoder
// Watches the request, result and key type channels, predicts the encoded
// byte stream of every accepted request and checks each popped byte in order.
// ----------------------------------------------------------------------------
module key_encoding_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  opk_pkg::request_t  request,
  input  logic               empty,
  input  logic               pop,
  input  opk_pkg::result_t   result,
  input  logic               cfg_we,
  input  opk_pkg::key_type_t cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 requests_seen,
  output int                 bytes_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] SIGN64      = 64'h8000_0000_0000_0000;
  localparam logic [31:0] SIGN32      = 32'h8000_0000;
  localparam logic [7:0]  STR_ESCAPE  = 8'h01;  // prefix, and the largest byte needing it
  localparam logic [7:0]  STR_TERM    = 8'h00;

  opk_pkg::result_t   expected_bytes[$];
  opk_pkg::key_type_t enc_key_type;

  function automatic void add_byte(logic [7:0] b, logic last, logic is_empty);
    opk_pkg::result_t r;
    r.out_byte  = b;
    r.key_last  = last;
    r.key_empty = is_empty;
    expected_bytes.insert(expected_bytes.size(), r);
  endfunction

  // Big-endian; the final byte carries key_last only when asked.
  function automatic void add_word(logic [63:0] w, int nbytes, logic final_word);
    for (int i = nbytes - 1; i >= 0; i--)
      add_byte(w[i*8 +: 8], final_word && (i == 0), 1'b0);
  endfunction

  function automatic void encode_key(opk_pkg::request_t req);
    logic [63:0] v;
    logic [31:0] f;
    int          nbytes;
    if (req.key_null) begin
      add_byte(8'h00, 1'b1, 1'b1);
      return;
    end
    if (enc_key_type <= opk_pkg::KT_INT64) begin
      nbytes = 1 << enc_key_type[1:0];
      v = req.value_low;
      if (nbytes < 8) v &= (64'h1 << (nbytes * 8)) - 64'h1;
      if (enc_key_type >= opk_pkg::KT_INT8) v[nbytes*8-1] = ~v[nbytes*8-1];
      add_word(v, nbytes, 1'b1);
      return;
    end
    case (enc_key_type)
      opk_pkg::KT_UINT128, opk_pkg::KT_INT128: begin
        v = req.value_high;
        if (enc_key_type == opk_pkg::KT_INT128) v ^= SIGN64;
        add_word(v, 8, 1'b0);
        add_word(req.value_low, 8, 1'b1);
      end
      opk_pkg::KT_FLOAT: begin
        f = req.value_low[31:0];
        f = f[31] ? ~f : (f ^ SIGN32);
        add_word({32'h0, f}, 4, 1'b1);
      end
      opk_pkg::KT_DOUBLE: begin
        v = req.value_low[63] ? ~req.value_low : (req.value_low ^ SIGN64);
        add_word(v, 8, 1'b1);
      end
      opk_pkg::KT_STRING: begin
        if (req.char_valid) begin
          if (req.char_byte <= STR_ESCAPE) add_byte(STR_ESCAPE, 1'b0, 1'b0);
          add_byte(req.char_byte, 1'b0, 1'b0);
        end
        if (req.string_end) add_byte(STR_TERM, 1'b1, 1'b0);
      end
      opk_pkg::KT_BOOL: add_byte({7'd0, req.value_low != 64'd0}, 1'b1, 1'b0);
      default: ;
    endcase
  endfunction

  function automatic void flag_mismatch(string what, logic [7:0] want, logic [7:0] got);
    fail_count++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
  endfunction

  always @(posedge clk) begin
    opk_pkg::result_t want;
    if (rst) begin
      expected_bytes.delete();
      enc_key_type  = opk_pkg::KEY_TYPE_RESET;
      fail_count    = 0;
      requests_seen = 0;
      bytes_seen    = 0;
      pending      <= 0;
    end else begin
      if (push && !full) begin
        requests_seen++;
        encode_key(request);
      end
      if (pop && !empty) begin
        bytes_seen++;
        if (expected_bytes.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, got byte %0h last %0b empty %0b",
                   $time, result.out_byte, result.key_last, result.key_empty);
        end else begin
          want = expected_bytes.pop_front();
          if (result.out_byte !== want.out_byte)
            flag_mismatch("out_byte", want.out_byte, result.out_byte);
          if (result.key_last !== want.key_last)
            flag_mismatch("key_last", want.key_last, result.key_last);
          if (result.key_empty !== want.key_empty)
            flag_mismatch("key_empty", want.key_empty, result.key_empty);
        end
      end
      if (cfg_we) enc_key_type = cfg_data;
      pending <= expected_bytes.size();
    end
  end

endmodule

// ===== bench/tb_order_preserving_key_encoder.sv =====
// ----------------------------------------------------------------------------
// tb_order_preserving_key_encoder: stimulus and verdict for the key encoder
// Runs a directed pass over every key type and special case, then random
// requests per key type under changing traffic mixes, with a long receiver
// hold-off; a separate checker predicts and compares every result byte.
// ----------------------------------------------------------------------------
module tb_order_preserving_key_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off, fills the job queue
  localparam int WATCHDOG_LIMIT = 4000;  // cycles without any handshake
  localparam int SETTLE_CYCLES  = 6;     // covers queue write plus serializer load
  localparam int TAIL_CYCLES    = 40;

  typedef enum int {FLOW_FREE, FLOW_SENDER_IDLE, FLOW_RECEIVER_STALL, FLOW_BOTH} flow_t;

  logic               clk;
  logic               rst;
  logic               push;
  logic               full;
  opk_pkg::request_t  request;
  logic               empty;
  logic               pop;
  opk_pkg::result_t   result;
  logic               cfg_we;
  opk_pkg::key_type_t cfg_data;

  int fail_count;
  int pending;
  int requests_seen;
  int bytes_seen;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;
  bit hold_go        = 1'b0;

  order_preserving_key_encoder uut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .request  (request),
    .empty    (empty),
    .pop      (pop),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  key_encoding_checker encoding_check (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .request       (request),
    .empty         (empty),
    .pop           (pop),
    .result        (result),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .requests_seen (requests_seen),
    .bytes_seen    (bytes_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: pop at random, or hold off for a counted stretch when asked.
  initial begin
    int hold_left;
    hold_left = 0;
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: count cycles in which neither side moves anything.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("timeout: no request or result moved for %0d cycles, %0d bytes outstanding",
             WATCHDOG_LIMIT, pending);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void set_flow(flow_t f);
    case (f)
      FLOW_FREE:           begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      FLOW_SENDER_IDLE:    begin send_idle_pct = 75; recv_stall_pct = 0;  end
      FLOW_RECEIVER_STALL: begin send_idle_pct = 0;  recv_stall_pct = 75; end
      default:             begin send_idle_pct = 20; recv_stall_pct = 20; end
    endcase
  endfunction

  // Bias toward all-zero, all-one, single-bit and sign-boundary words.
  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(5))
      0: w = '0;
      1: w = '1;
      2: w = 64'h1 << $urandom_range(63);
      3: w = (64'h1 << $urandom_range(63)) - 64'h1;
      default: ;
    endcase
    return w;
  endfunction

  function automatic opk_pkg::request_t mk(logic [63:0] lo, logic [63:0] hi = '0,
                                           logic [7:0] c = '0, bit valid = 1'b0,
                                           bit last = 1'b0, bit is_null = 1'b0);
    opk_pkg::request_t r;
    r.value_low  = lo;
    r.value_high = hi;
    r.char_byte  = c;
    r.char_valid = valid;
    r.string_end = last;
    r.key_null   = is_null;
    return r;
  endfunction

  // Every field random; a null key now and then.
  function automatic opk_pkg::request_t random_request();
    return mk(rand_word(), rand_word(), 8'($urandom), 1'($urandom), 1'($urandom),
              $urandom_range(15) == 0);
  endfunction

  // Hold push high from one request to the next; lower it only while idling.
  task automatic send(input opk_pkg::request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    request <= r;
    do @(posedge clk); while (full);
  endtask

  // Stop offering, wait out every expected byte, then let in-flight
  // requests that make no bytes clear the pipeline.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_key_type(input opk_pkg::key_type_t kt);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= kt;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Mostly whole strings (escaped low bytes, terminator on the last request),
  // with the odd random request mixed in: nulls, empty items, cut-off strings.
  task automatic send_strings(input int count);
    int sent;
    int len;
    logic [7:0] c;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) == 0) begin
        send(random_request());
        sent++;
      end else begin
        len = $urandom_range(5);
        if (len == 0) begin
          send(mk(rand_word(), rand_word(), 8'($urandom), 1'b0, 1'b1));
          sent++;
        end
        for (int i = 0; i < len; i++) begin
          c = ($urandom_range(3) == 0) ? 8'($urandom_range(1)) : 8'($urandom);
          send(mk(rand_word(), rand_word(), c, 1'b1, i == len - 1));
          sent++;
        end
      end
    end
  endtask

  initial begin
    opk_pkg::key_type_t kt;
    rst      = 1'b1;
    push     = 1'b0;
    request  = '0;
    cfg_we   = 1'b0;
    cfg_data = opk_pkg::KEY_TYPE_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed pass: extremes of each key type and the special cases.
    set_flow(FLOW_BOTH);
    send(mk(64'h0));                               // uint64 from reset, smallest
    send(mk(64'h0, 64'h0, 8'h0, 1'b0, 1'b0, 1'b1)); // null key
    set_key_type(opk_pkg::KT_UINT8);
    send(mk('1));                                  // junk above the low byte
    set_key_type(opk_pkg::KT_UINT16);
    send(mk(64'h0));
    set_key_type(opk_pkg::KT_UINT32);
    send(mk(64'h1234_5678_FFFF_FFFF));
    set_key_type(opk_pkg::KT_INT8);
    send(mk(64'hFFFF_FFFF_FFFF_FF80));             // most negative, junk above
    set_key_type(opk_pkg::KT_INT16);
    send(mk(64'h7FFF));                            // most positive
    set_key_type(opk_pkg::KT_INT32);
    send(mk(64'hFFFF_0000_8000_0000));
    set_key_type(opk_pkg::KT_INT64);
    send(mk('1));
    set_key_type(opk_pkg::KT_UINT128);
    send(mk(64'h0, '1));
    set_key_type(opk_pkg::KT_INT128);
    send(mk('1, 64'h8000_0000_0000_0000));
    set_key_type(opk_pkg::KT_FLOAT);
    send(mk(64'hDEAD_BEEF_8000_0000));             // negative zero, junk above
    send(mk(64'hFFFF_FFFF_7F80_0000));             // positive infinity
    set_key_type(opk_pkg::KT_DOUBLE);
    send(mk(64'h8000_0000_0000_0000));
    send(mk(64'h0));
    set_key_type(opk_pkg::KT_STRING);
    send(mk(64'h0, 64'h0, 8'h00, 1'b1));           // escaped zero
    send(mk(64'h0, 64'h0, 8'h01, 1'b1));           // escaped one
    send(mk(64'h0, 64'h0, 8'h41, 1'b0));           // empty item, no result
    send(mk(64'h0, 64'h0, 8'h41, 1'b1, 1'b0, 1'b1)); // null in mid-string
    send(mk(64'h0, 64'h0, 8'hFF, 1'b1, 1'b1));     // last character plus terminator
    send(mk(64'h0, 64'h0, 8'h00, 1'b0, 1'b1));     // terminator only
    set_key_type(opk_pkg::KT_BOOL);
    send(mk(64'h0));
    send(mk(64'h8000_0000_0000_0000));
    set_key_type(opk_pkg::key_type_t'(14));
    send(random_request());                        // unknown type, nothing out
    set_key_type(opk_pkg::key_type_t'(15));
    send(random_request());

    // Random pass: every key type code in turn, traffic mix rotating.
    for (int k = 0; k < 16; k++) begin
      kt = opk_pkg::key_type_t'(k);
      set_flow(flow_t'(k % 4));
      set_key_type(kt);
      if (kt == opk_pkg::KT_UINT128) hold_go = 1'b1;  // sixteen bytes each: fills up fast
      if (kt == opk_pkg::KT_STRING) begin
        send_strings(14);
        drain();                             // pause the sender mid-phase
        send_strings(14);
      end else begin
        repeat ((kt > opk_pkg::KT_BOOL) ? 3 : 9) send(random_request());
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Encoded %0d key requests into %0d result bytes over key type codes 0 to 15,",
             requests_seen, bytes_seen);
    $display("with nulls, string escapes, idle and stalled traffic and a long hold-off.");
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
